// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the tiny two-register CPU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define ASSERT_SAME(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttrc_pkg.sv =====
// Package with types, constants and helpers of the tiny two-register CPU.
`default_nettype none

package ttrc_pkg;

  localparam int MEM_DEPTH = 256;              // power of two, 16 to 256
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int DATA_W    = 8;

  localparam logic [DATA_W-1:0] OP_ADDR     = 8'd0;
  localparam logic [DATA_W-1:0] TARGET_SLOT = 8'd1;
  localparam logic [DATA_W-1:0] RESTART_PC  = 8'd2;

  // Opcodes
  localparam logic [DATA_W-1:0] OP_HALT  = 8'd0;
  localparam logic [DATA_W-1:0] OP_ADD   = 8'd1;
  localparam logic [DATA_W-1:0] OP_LOAD0 = 8'd2;
  localparam logic [DATA_W-1:0] OP_LOAD1 = 8'd3;
  localparam logic [DATA_W-1:0] OP_BEEP  = 8'd4;
  localparam logic [DATA_W-1:0] OP_PRINT = 8'd5;
  localparam logic [DATA_W-1:0] OP_STORE = 8'd6;
  localparam logic [DATA_W-1:0] OP_JUMP  = 8'd7;
  localparam logic [DATA_W-1:0] OP_JEQ   = 8'd8;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_EXEC    = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACT,
    S_OPCOPY,
    S_OPER,
    S_IND,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_MEM_WRITE,
    CMD_MEM_READ,
    CMD_RESTART,
    CMD_FETCH,
    CMD_OPCOPY,
    CMD_EXECUTE,
    CMD_PRINT
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted transaction
    cmd_t cmd;
    logic result_load;  // move the item's outcome into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t action;
    logic    halted;
    logic    print_op;
  } dp_status_t;

  // One result item; read_data sits in the lowest bits
  typedef struct packed {
    logic [DATA_W-1:0] second_register;
    logic [DATA_W-1:0] accumulator;
    logic [DATA_W-1:0] program_counter;
    logic              halted;
    logic              beep;
    logic [DATA_W-1:0] print_value;
    logic              print_valid;
    logic [DATA_W-1:0] read_data;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [DATA_W-1:0] a);
    mem_idx = a[MEM_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ttrc_dp.sv =====
// Datapath of the tiny two-register CPU: memory, registers and result register.
`default_nettype none

`include "assert_macros.svh"

module ttrc_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ttrc_pkg::dp_cmd_t           cmd,
  input  wire logic [1:0]                  in_action,
  input  wire logic [ttrc_pkg::DATA_W-1:0] in_address,
  input  wire logic [ttrc_pkg::DATA_W-1:0] in_data,
  output ttrc_pkg::dp_status_t             status,
  output ttrc_pkg::result_t                result
);

  localparam int W = ttrc_pkg::DATA_W;

  ttrc_pkg::action_t action_r;
  logic [W-1:0] addr_r, data_r;
  logic [W-1:0] pc_r, pc_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic         halt_r, halt_nxt;
  logic [W-1:0] op_r, op_nxt;
  logic         beep_r, beep_nxt;
  logic         pv_r, pv_nxt;
  logic [W-1:0] pval_r, pval_nxt;
  logic [W-1:0] rdata_r;
  ttrc_pkg::result_t res_r;

  logic [W-1:0] mem [ttrc_pkg::MEM_DEPTH];
  logic [ttrc_pkg::MEM_DEPTH-1:0] valid_r;

  logic         rd_en, we;
  logic [W-1:0] rd_addr, wr_addr, wr_data;
  logic         jump_taken;

  assign jump_taken = (op_r == ttrc_pkg::OP_JUMP) ||
                      ((op_r == ttrc_pkg::OP_JEQ) && (a_r == b_r));

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = pc_r;
    we       = 1'b0;
    wr_addr  = addr_r;
    wr_data  = data_r;
    pc_nxt   = pc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    halt_nxt = halt_r;
    op_nxt   = op_r;
    beep_nxt = beep_r;
    pv_nxt   = pv_r;
    pval_nxt = pval_r;
    if (cmd.latch) begin
      beep_nxt = 1'b0;
      pv_nxt   = 1'b0;
      pval_nxt = '0;
    end
    unique case (cmd.cmd)
      ttrc_pkg::CMD_NONE: begin
      end
      ttrc_pkg::CMD_MEM_WRITE: begin
        we = 1'b1;
      end
      ttrc_pkg::CMD_MEM_READ: begin
        rd_en   = 1'b1;
        rd_addr = addr_r;
      end
      ttrc_pkg::CMD_RESTART: begin
        pc_nxt   = ttrc_pkg::RESTART_PC;
        halt_nxt = 1'b0;
      end
      ttrc_pkg::CMD_FETCH: begin
        rd_en = 1'b1;
      end
      ttrc_pkg::CMD_OPCOPY: begin
        // copy the opcode to its slot and read the operand at pc + 1
        we      = 1'b1;
        wr_addr = ttrc_pkg::OP_ADDR;
        wr_data = rdata_r;
        op_nxt  = rdata_r;
        pc_nxt  = pc_r + 8'd1;
        rd_en   = 1'b1;
        rd_addr = pc_r + 8'd1;
      end
      ttrc_pkg::CMD_EXECUTE: begin
        unique case (op_r)
          ttrc_pkg::OP_HALT:  halt_nxt = 1'b1;
          ttrc_pkg::OP_ADD:   a_nxt = a_r + b_r;
          ttrc_pkg::OP_LOAD0: begin
            a_nxt  = rdata_r;
            pc_nxt = pc_r + 8'd1;
          end
          ttrc_pkg::OP_LOAD1: begin
            b_nxt  = rdata_r;
            pc_nxt = pc_r + 8'd1;
          end
          ttrc_pkg::OP_BEEP:  beep_nxt = 1'b1;
          ttrc_pkg::OP_PRINT: begin
            b_nxt   = rdata_r;
            pc_nxt  = pc_r + 8'd1;
            rd_en   = 1'b1;
            rd_addr = rdata_r;
          end
          ttrc_pkg::OP_STORE: begin
            b_nxt   = rdata_r;
            pc_nxt  = pc_r + 8'd1;
            we      = 1'b1;
            wr_addr = rdata_r;
            wr_data = a_r;
          end
          ttrc_pkg::OP_JUMP, ttrc_pkg::OP_JEQ: begin
            if (jump_taken) begin
              we      = 1'b1;
              wr_addr = ttrc_pkg::TARGET_SLOT;
              wr_data = rdata_r;
              pc_nxt  = rdata_r;
            end else begin
              pc_nxt = pc_r + 8'd1;
            end
          end
          default: begin
          end
        endcase
      end
      ttrc_pkg::CMD_PRINT: begin
        a_nxt    = rdata_r;
        pv_nxt   = 1'b1;
        pval_nxt = rdata_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= ttrc_pkg::RESTART_PC;
      a_r    <= '0;
      b_r    <= '0;
      halt_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action_r <= ttrc_pkg::action_t'(in_action);
      addr_r   <= in_address;
      data_r   <= in_data;
    end
    op_r   <= op_nxt;
    beep_r <= beep_nxt;
    pv_r   <= pv_nxt;
    pval_r <= pval_nxt;
    if (cmd.result_load) begin
      res_r.read_data       <= (action_r == ttrc_pkg::ACT_READ) ? rdata_r : '0;
      res_r.print_valid     <= pv_r;
      res_r.print_value     <= pval_r;
      res_r.beep            <= beep_r;
      res_r.halted          <= halt_r;
      res_r.program_counter <= pc_r;
      res_r.accumulator     <= a_r;
      res_r.second_register <= b_r;
    end
  end

  // Byte memory, write-first; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[ttrc_pkg::mem_idx(wr_addr)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ttrc_pkg::mem_idx(wr_addr)] <= wr_data;
    end
    if (rd_en) begin
      if (we && (ttrc_pkg::mem_idx(wr_addr) == ttrc_pkg::mem_idx(rd_addr))) begin
        rdata_r <= wr_data;
      end else if (valid_r[ttrc_pkg::mem_idx(rd_addr)]) begin
        rdata_r <= mem[ttrc_pkg::mem_idx(rd_addr)];
      end else begin
        rdata_r <= '0;
      end
    end
  end

  assign status.action   = action_r;
  assign status.halted   = halt_r;
  assign status.print_op = (op_r == ttrc_pkg::OP_PRINT);
  assign result          = res_r;

  `ASSERT_NEXT(a_restart_pc, cmd.cmd == ttrc_pkg::CMD_RESTART,
    pc_r == ttrc_pkg::RESTART_PC && !halt_r, "restart did not reload pc and halt")
  `ASSERT_SAME(a_fetch_running, cmd.cmd == ttrc_pkg::CMD_FETCH, !halt_r,
    "fetch issued while halted")
  `ASSERT_NEXT(a_jump_target, cmd.cmd == ttrc_pkg::CMD_EXECUTE && jump_taken,
    pc_r == $past(rdata_r), "taken jump did not load its target")

endmodule

`default_nettype wire

// ===== rtl/ttrc_ctrl.sv =====
// Controller state machine of the tiny two-register CPU.
`default_nettype none

`include "assert_macros.svh"

module ttrc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire ttrc_pkg::dp_status_t status,
  output ttrc_pkg::dp_cmd_t         cmd
);

  ttrc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttrc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd.latch       = 1'b0;
    cmd.cmd         = ttrc_pkg::CMD_NONE;
    cmd.result_load = 1'b0;
    in_tready       = 1'b0;
    unique case (state_r)
      ttrc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = ttrc_pkg::S_ACT;
        end
      end
      ttrc_pkg::S_ACT: begin
        state_nxt = ttrc_pkg::S_DONE;
        unique case (status.action)
          ttrc_pkg::ACT_WRITE:   cmd.cmd = ttrc_pkg::CMD_MEM_WRITE;
          ttrc_pkg::ACT_READ:    cmd.cmd = ttrc_pkg::CMD_MEM_READ;
          ttrc_pkg::ACT_RESTART: cmd.cmd = ttrc_pkg::CMD_RESTART;
          ttrc_pkg::ACT_EXEC: begin
            if (!status.halted) begin
              cmd.cmd   = ttrc_pkg::CMD_FETCH;
              state_nxt = ttrc_pkg::S_OPCOPY;
            end
          end
          default: begin
          end
        endcase
      end
      ttrc_pkg::S_OPCOPY: begin
        cmd.cmd   = ttrc_pkg::CMD_OPCOPY;
        state_nxt = ttrc_pkg::S_OPER;
      end
      ttrc_pkg::S_OPER: begin
        cmd.cmd   = ttrc_pkg::CMD_EXECUTE;
        state_nxt = status.print_op ? ttrc_pkg::S_IND : ttrc_pkg::S_DONE;
      end
      ttrc_pkg::S_IND: begin
        cmd.cmd   = ttrc_pkg::CMD_PRINT;
        state_nxt = ttrc_pkg::S_DONE;
      end
      ttrc_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.result_load = 1'b1;
          state_nxt       = ttrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ttrc_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.result_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  `ASSERT_NEXT(a_accept_dispatch, in_tvalid && in_tready, state_r == ttrc_pkg::S_ACT,
    "accepted transaction not dispatched")
  `ASSERT_NEXT(a_done_stall,
    state_r == ttrc_pkg::S_DONE && out_valid_r && !out_tready,
    state_r == ttrc_pkg::S_DONE && out_valid_r, "result overwritten while stalled")
  `ASSERT_SAME(a_valid_source, $rose(out_valid_r), $past(state_r) == ttrc_pkg::S_DONE,
    "result raised outside completion")

endmodule

`default_nettype wire

// ===== rtl/tiny_two_register_cpu.sv =====
// Top level of the tiny two-register CPU: stream ports, controller and datapath.
`default_nettype none

// Tiny 8-bit CPU with two byte registers, a byte program counter, a halt flag
// and a 256-byte memory that reads as zero after reset. Each input transaction
// carries an action in in_tuser: write a memory byte, read a memory byte,
// restart (pc back to 2, halt cleared) or execute one instruction; every
// transaction returns exactly one result transaction with the read byte, the
// print and beep events and the register state after the item. The block
// works on one item at a time: write, read, restart and execute-while-halted
// pass the action and completion states, an instruction adds opcode copy and
// execute, and print adds the indirect read. The byte memory has one read
// port, one write port and a registered read, so fetch, opcode copy, operand
// read and the indirect read or store follow one another. A finished result
// waits in the output register while the next transaction is accepted; the
// block only stalls at completion if that register is still full.
module tiny_two_register_cpu (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [15:0]               in_tdata,   // address[7:0], data[15:8]
  input  wire logic [1:0]                in_tuser,   // action[1:0]
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // read_data[7:0], print_valid[8], print_value[16:9], beep[17], halted[18],
  // program_counter[26:19], accumulator[34:27], second_register[42:35],
  // zeros above
  output logic [ttrc_pkg::OUT_W-1:0]     out_tdata
);

  ttrc_pkg::dp_cmd_t    cmd;
  ttrc_pkg::dp_status_t status;
  ttrc_pkg::result_t    result;

  ttrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ttrc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_action  (in_tuser),
    .in_address (in_tdata[7:0]),
    .in_data    (in_tdata[15:8]),
    .status     (status),
    .result     (result)
  );

  // pad the result up to whole bytes
  assign out_tdata = {{(ttrc_pkg::OUT_W - ttrc_pkg::RESULT_W){1'b0}}, result};

endmodule

`default_nettype wire
